// ----- sv/mheq_pkg.sv -----
// package: types, constants and command codes of the min-heap event queue
`default_nettype none
package mheq_pkg;
   localparam int CAPACITY   = 1024;
   localparam int GRID_SIZE  = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 32;
   localparam int COORD_W    = $clog2(GRID_SIZE);
   localparam int ENTRY_W    = KEY_W + 2 * COORD_W;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_POP_RD,
      ST_POP_LAST,
      ST_DOWN_RDL,
      ST_DOWN_RDR,
      ST_DOWN_CMP,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       push_init;
      logic       push_rd_parent;
      logic       push_step;
      logic       push_end;
      logic       pop_init;
      logic       pop_rd_last;
      logic       pop_last;
      logic       rd_left;
      logic       rd_right;
      logic       down_step;
      logic       down_end;
      logic       set_full;
      logic       set_empty;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
      logic at_root;
      logic parent_le;
      logic count_one;
      logic left_ok;
      logic right_ok;
      logic down_swap;
   } stat_type;
endpackage
`default_nettype wire

// ----- sv/mheq_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module mheq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ----- sv/mheq_ctrl.sv -----
// controller state machine of the min-heap event queue
`default_nettype none
module mheq_ctrl import mheq_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_PUSH_RD;
            end
         end
         ST_PUSH_RD: begin
            if (!stat.is_pop) begin
               if (stat.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.push_init = 1'b1;
                  state_in      = ST_PUSH_CMP;
               end
            end else if (stat.empty) begin
               cmd.set_empty = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.pop_init = 1'b1;
               state_in     = ST_POP_RD;
            end
         end
         ST_PUSH_CMP: begin
            if (stat.at_root) begin
               cmd.push_end = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.push_rd_parent = 1'b1;
               state_in           = ST_POP_LAST;
            end
         end
         ST_POP_LAST: begin
            if (!stat.is_pop) begin
               if (stat.parent_le) begin
                  cmd.push_end = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.push_step = 1'b1;
                  state_in      = ST_PUSH_CMP;
               end
            end else begin
               cmd.pop_last = 1'b1;
               state_in     = stat.count_one ? ST_DONE : ST_DOWN_RDL;
            end
         end
         ST_POP_RD: begin
            cmd.pop_rd_last = 1'b1;
            state_in        = ST_POP_LAST;
         end
         ST_DOWN_RDL: begin
            if (!stat.left_ok) begin
               cmd.down_end = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_left = 1'b1;
               state_in    = ST_DOWN_RDR;
            end
         end
         ST_DOWN_RDR: begin
            cmd.rd_right = 1'b1;
            state_in     = ST_DOWN_CMP;
         end
         ST_DOWN_CMP: begin
            if (stat.down_swap) begin
               cmd.down_step = 1'b1;
               state_in      = ST_DOWN_RDL;
            end else begin
               cmd.down_end = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- sv/mheq_dp.sv -----
// datapath of the min-heap event queue: heap ram, count, sift registers
`default_nettype none
module mheq_dp import mheq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_cmd,
   input  wire logic [KEY_W-1:0]   req_key_time,
   input  wire logic [COORD_W-1:0] req_cell_row,
   input  wire logic [COORD_W-1:0] req_cell_col,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   output logic [KEY_W-1:0]        rsp_out_time,
   output logic [COORD_W-1:0]      rsp_out_row,
   output logic [COORD_W-1:0]      rsp_out_col,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_empty,
   output logic [COUNT_W-1:0]      rsp_entry_count
);
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               op_ff;
   entry_type          cur_ff, cur_in;      // entry being sifted
   entry_type          res_ff, res_in;      // popped entry
   entry_type          left_ff;
   logic [1:0]         status_ff, status_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0]  par_ff, par_in;
   logic               right_ok_ff;

   logic               we;
   logic [ADDR_W-1:0]  addr;
   entry_type          wdata;
   entry_type          rdata;
   logic [COUNT_W:0]   left_idx, right_idx;
   logic               use_right;

   mheq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign left_idx  = {pos_ff, 1'b1} + (COUNT_W + 1)'(0);
   assign right_idx = left_idx + (COUNT_W + 1)'(1);
   assign use_right = right_ok_ff && (rdata.key < left_ff.key);

   always_comb begin
      stat           = '0;
      stat.is_pop    = op_ff;
      stat.full      = count_ff == COUNT_W'(CAPACITY);
      stat.empty     = count_ff == '0;
      stat.at_root   = pos_ff == '0;
      stat.parent_le = rdata.key <= cur_ff.key;
      stat.count_one = count_ff == '0;
      stat.left_ok   = left_idx < (COUNT_W + 1)'(count_ff);
      stat.down_swap = use_right ? (rdata.key < cur_ff.key) : (left_ff.key < cur_ff.key);
   end

   always_comb begin
      count_in  = count_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      par_in    = par_ff;
      we        = 1'b0;
      addr      = pos_ff;
      wdata     = cur_ff;
      if (cmd.load_req) begin
         cur_in    = '{key: req_key_time, row: req_cell_row, col: req_cell_col};
         status_in = STATUS_OK;
         res_in    = '0;
         addr      = '0;
      end
      if (cmd.set_full)  status_in = STATUS_FULL;
      if (cmd.set_empty) status_in = STATUS_EMPTY;
      if (cmd.push_init) begin
         pos_in   = ADDR_W'(count_ff);
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.push_rd_parent) begin
         par_in = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
         addr   = par_in;
      end
      if (cmd.push_step) begin
         we     = 1'b1;
         addr   = pos_ff;
         wdata  = rdata;
         pos_in = par_ff;
      end
      if (cmd.push_end) begin
         we = 1'b1;
      end
      if (cmd.pop_init) begin
         res_in   = rdata;
         count_in = count_ff - COUNT_W'(1);
         pos_in   = '0;
      end
      if (cmd.pop_rd_last) begin
         addr = ADDR_W'(count_ff);
      end
      if (cmd.pop_last) begin
         cur_in = rdata;
      end
      if (cmd.rd_left) begin
         addr = left_idx[ADDR_W-1:0];
      end
      if (cmd.rd_right) begin
         addr = right_idx[ADDR_W-1:0];
      end
      if (cmd.down_step) begin
         we    = 1'b1;
         wdata = use_right ? rdata : left_ff;
         pos_in = use_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
      end
      if (cmd.down_end) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.load_req) op_ff <= req_cmd;
      cur_ff    <= cur_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      par_ff    <= par_in;
      if (cmd.rd_right) begin
         left_ff     <= rdata;
         right_ok_ff <= right_idx < (COUNT_W + 1)'(count_ff);
      end
      if (cmd.rsp_load) begin
         rsp_out_time    <= res_ff.key;
         rsp_out_row     <= res_ff.row;
         rsp_out_col     <= res_ff.col;
         rsp_status      <= status_ff;
         rsp_is_empty    <= count_ff == '0;
         rsp_entry_count <= count_ff;
      end
   end
endmodule
`default_nettype wire

// ----- sv/min_heap_event_queue.sv -----
// top level of the min-heap event queue
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | cmd, key_time, cell_row, cell_col
// rsp     | out       | rsp_valid / rsp_ready | out_time, out_row, out_col, status,
//         |           |                       | is_empty, entry_count
// one item at a time; a push climbs from the new leaf by parent reads and compares;
// a pop moves the last entry to the root and sinks it by left and right child reads;
// a full push or an empty pop skips the walk; all steps share the single ram port
// reset clears the count and the controller; heap contents need no clearing
// a held result blocks the next item only once its own work is finished
`default_nettype none
module min_heap_event_queue import mheq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [KEY_W-1:0]   req_key_time,
   input  wire logic [COORD_W-1:0] req_cell_row,
   input  wire logic [COORD_W-1:0] req_cell_col,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [KEY_W-1:0]        rsp_out_time,
   output logic [COORD_W-1:0]      rsp_out_row,
   output logic [COORD_W-1:0]      rsp_out_col,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_empty,
   output logic [COUNT_W-1:0]      rsp_entry_count
);
   cmd_type  cmd;
   stat_type stat;

   mheq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mheq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_key_time    (req_key_time),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_out_time    (rsp_out_time),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count)
   );
endmodule
`default_nettype wire

// ----- sv/mheq_checker.sv -----
// port checker of the min-heap event queue and its bind
`default_nettype none
module mheq_checker import mheq_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [KEY_W-1:0]   rsp_out_time,
   input wire logic [1:0]         rsp_status,
   input wire logic               rsp_is_empty,
   input wire logic [COUNT_W-1:0] rsp_entry_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("rsp not held");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_entry_count == '0))
      else $error("empty flag mismatch");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_out_time == '0)
      else $error("error result carries data");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer accepted while busy");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_W'(CAPACITY))
      else $error("count above capacity");
endmodule

bind min_heap_event_queue mheq_checker u_mheq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_time    (rsp_out_time),
   .rsp_status      (rsp_status),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire
